// File: rtl/clsup_pkg.sv
// Package for the CAN link supervisor: item, result and register types,
// opcodes, register indexes and LED codes. No dependencies.
`default_nettype none
package clsup_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_FRAME = 2'd1;
  localparam logic [1:0] OP_POLL  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_ACCEPTED_ID    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_MS     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CRITICAL_CODE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_CODE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_RPM_CODE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OVER_TEMP_CODE = 3'd5;

  localparam logic [3:0] LED_OFF    = 4'b0000;
  localparam logic [3:0] LED_RED    = 4'b0001;
  localparam logic [3:0] LED_YELLOW = 4'b0010;
  localparam logic [3:0] LED_BLUE   = 4'b0100;
  localparam logic [3:0] LED_GREEN  = 4'b1000;

  localparam logic [15:0] SEQ_HALF_RANGE = 16'h8000;
  localparam int          BLINK_BIT      = 9;
  localparam logic [3:0]  REQUIRED_DLC   = 4'd8;

  typedef struct packed {
    logic [1:0]  opcode;
    logic        extended_flag;
    logic        remote_flag;
    logic [28:0] frame_id;
    logic [3:0]  length_code;
    logic        payload_ok;
    logic [15:0] sequence_req;
    logic [7:0]  vehicle_state;
    logic [7:0]  fault;
  } item_t;

  typedef struct packed {
    logic [3:0]  led_pattern;
    logic        timed_out;
    logic        recovered_event;
    logic        timeout_event;
    logic        payload_error;
    logic [31:0] valid_count;
    logic [31:0] lost_count;
    logic [31:0] overflow_count;
    logic [31:0] wrong_count;
  } result_t;

  typedef struct packed {
    logic [10:0] accepted_id;
    logic [15:0] timeout_ms;
    logic [7:0]  critical_code;
    logic [7:0]  normal_code;
    logic [7:0]  high_rpm_code;
    logic [7:0]  over_temp_code;
  } cfg_t;

  typedef struct packed {
    logic        ok;
    logic [15:0] seq;
    logic [7:0]  vstate;
    logic [7:0]  flt;
  } slot_t;

endpackage
`default_nettype wire

// File: rtl/can_link_supervisor_unit.sv
// Top level of the CAN link supervisor: input register, link state core,
// result register and configuration registers. Depends on clsup_pkg, clsup_cfg and clsup_core.
// Each item waits in the input register and moves into the result register
// when the output is not stalled.
// Throughput: one item per cycle while result_stall does not hold the output.
// Reset (rst, synchronous): counters, timers, the slot pending flag and LEDs clear,
// registers return to their defaults; the slot contents are not reset.
`default_nettype none
module can_link_supervisor_unit import clsup_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  item_valid,
  output logic                       item_stall,
  input  wire item_t                 item,
  output logic                       result_valid,
  input  wire logic                  result_stall,
  output result_t                    result,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t    cfg;
  logic    in_full;
  item_t   in_item;
  logic    advance;
  result_t core_result;

  assign cfg_ready  = 1'b1;
  assign advance    = in_full && (!result_valid || !result_stall);
  assign item_stall = in_full && !advance;

  clsup_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  clsup_core u_core (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .fire   (advance),
    .item   (in_item),
    .result (core_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (item_valid && !item_stall) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      in_item <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= core_result;
    end
  end

endmodule
`default_nettype wire

// File: rtl/clsup_cfg.sv
// Configuration register file of the CAN link supervisor.
// Depends on clsup_pkg.
`default_nettype none
module clsup_cfg import clsup_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  wr_en,
  input  wire logic [CFG_IDX_W-1:0]  wr_index,
  input  wire logic [CFG_DATA_W-1:0] wr_data,
  output cfg_t                       cfg
);

  cfg_t regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.accepted_id    <= 11'd513;
      regs.timeout_ms     <= 16'd1000;
      regs.critical_code  <= 8'd3;
      regs.normal_code    <= 8'd0;
      regs.high_rpm_code  <= 8'd1;
      regs.over_temp_code <= 8'd2;
    end else if (wr_en) begin
      case (wr_index)
        REG_ACCEPTED_ID:    regs.accepted_id    <= wr_data[10:0];
        REG_TIMEOUT_MS:     regs.timeout_ms     <= wr_data[15:0];
        REG_CRITICAL_CODE:  regs.critical_code  <= wr_data[7:0];
        REG_NORMAL_CODE:    regs.normal_code    <= wr_data[7:0];
        REG_HIGH_RPM_CODE:  regs.high_rpm_code  <= wr_data[7:0];
        REG_OVER_TEMP_CODE: regs.over_temp_code <= wr_data[7:0];
        default: ;
      endcase
    end
  end

  assign cfg = regs;

endmodule
`default_nettype wire

// File: rtl/clsup_core.sv
// Link state of the CAN link supervisor: frame filter, slot, counters,
// timeout and LED logic. Computes one result per item. Depends on clsup_pkg.
`default_nettype none
module clsup_core import clsup_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire cfg_t  cfg,
  input  wire logic  fire,
  input  wire item_t item,
  output result_t    result
);

  logic [31:0] now_ms, now_ms_next;
  logic [31:0] last_valid_time, last_valid_time_next;
  logic [15:0] previous_sequence, previous_sequence_next;
  logic        sequence_seen, sequence_seen_next;
  logic        timeout_flag, timeout_flag_next;
  logic        slot_pending, slot_pending_next;
  slot_t       slot_contents;
  logic        slot_write;
  logic [31:0] valid_count, valid_count_next;
  logic [31:0] lost_count, lost_count_next;
  logic [31:0] overflow_count, overflow_count_next;
  logic [31:0] wrong_count, wrong_count_next;
  logic [3:0]  led_latch, led_latch_next;

  logic        hit, good, recovered, declared, bad;
  logic [15:0] gap;
  logic [31:0] elapsed;
  logic [3:0]  state_led;

  always_comb begin
    if (slot_contents.flt != 8'd0 || slot_contents.vstate == cfg.critical_code) begin
      state_led = LED_RED;
    end else if (slot_contents.vstate == cfg.normal_code) begin
      state_led = LED_YELLOW;
    end else if (slot_contents.vstate == cfg.high_rpm_code) begin
      state_led = LED_BLUE;
    end else if (slot_contents.vstate == cfg.over_temp_code) begin
      state_led = LED_GREEN;
    end else begin
      state_led = LED_OFF;
    end
  end

  assign hit = !item.extended_flag && !item.remote_flag
             && item.frame_id == {18'd0, cfg.accepted_id}
             && item.length_code == REQUIRED_DLC;
  assign gap     = slot_contents.seq - previous_sequence;
  assign elapsed = now_ms - last_valid_time;

  always_comb begin
    now_ms_next            = now_ms;
    last_valid_time_next   = last_valid_time;
    previous_sequence_next = previous_sequence;
    sequence_seen_next     = sequence_seen;
    timeout_flag_next      = timeout_flag;
    slot_pending_next      = slot_pending;
    slot_write             = 1'b0;
    valid_count_next       = valid_count;
    lost_count_next        = lost_count;
    overflow_count_next    = overflow_count;
    wrong_count_next       = wrong_count;
    led_latch_next         = led_latch;
    good                   = 1'b0;
    recovered              = 1'b0;
    declared               = 1'b0;
    bad                    = 1'b0;
    case (item.opcode)
      OP_TICK: begin
        now_ms_next = now_ms + 32'd1;
      end
      OP_FRAME: begin
        if (hit) begin
          if (slot_pending) begin
            overflow_count_next = overflow_count + 32'd1;
          end
          slot_write        = 1'b1;
          slot_pending_next = 1'b1;
        end else begin
          wrong_count_next = wrong_count + 32'd1;
        end
      end
      OP_POLL: begin
        slot_pending_next = 1'b0;
        good = slot_pending && slot_contents.ok;
        bad  = slot_pending && !slot_contents.ok;
        if (good) begin
          valid_count_next = valid_count + 32'd1;
          if (sequence_seen && gap > 16'd1 && gap < SEQ_HALF_RANGE) begin
            lost_count_next = lost_count + {16'd0, gap - 16'd1};
          end
          previous_sequence_next = slot_contents.seq;
          sequence_seen_next     = 1'b1;
          last_valid_time_next   = now_ms;
          recovered              = timeout_flag;
          timeout_flag_next      = 1'b0;
          led_latch_next         = state_led;
        end
        declared = !good && !timeout_flag && elapsed > {16'd0, cfg.timeout_ms};
        if (declared) begin
          timeout_flag_next = 1'b1;
        end
        if (timeout_flag_next) begin
          led_latch_next = now_ms[BLINK_BIT] ? LED_YELLOW : LED_RED;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      now_ms            <= '0;
      last_valid_time   <= '0;
      previous_sequence <= '0;
      sequence_seen     <= 1'b0;
      timeout_flag      <= 1'b0;
      slot_pending      <= 1'b0;
      valid_count       <= '0;
      lost_count        <= '0;
      overflow_count    <= '0;
      wrong_count       <= '0;
      led_latch         <= LED_OFF;
    end else if (fire) begin
      now_ms            <= now_ms_next;
      last_valid_time   <= last_valid_time_next;
      previous_sequence <= previous_sequence_next;
      sequence_seen     <= sequence_seen_next;
      timeout_flag      <= timeout_flag_next;
      slot_pending      <= slot_pending_next;
      valid_count       <= valid_count_next;
      lost_count        <= lost_count_next;
      overflow_count    <= overflow_count_next;
      wrong_count       <= wrong_count_next;
      led_latch         <= led_latch_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && slot_write) begin
      slot_contents.ok     <= item.payload_ok;
      slot_contents.seq    <= item.sequence_req;
      slot_contents.vstate <= item.vehicle_state;
      slot_contents.flt    <= item.fault;
    end
  end

  always_comb begin
    result.led_pattern     = led_latch_next;
    result.timed_out       = timeout_flag_next;
    result.recovered_event = recovered;
    result.timeout_event   = declared;
    result.payload_error   = bad;
    result.valid_count     = valid_count_next;
    result.lost_count      = lost_count_next;
    result.overflow_count  = overflow_count_next;
    result.wrong_count     = wrong_count_next;
  end

endmodule
`default_nettype wire

// File: tb/sv/can_link_supervisor_unit_tb.sv
// Self-checking bench for can_link_supervisor_unit: a directed table, then random
// tick/frame/poll traffic under several register settings, with an in-bench link model.
// Depends on clsup_pkg and the can_link_supervisor_unit RTL.
module can_link_supervisor_unit_tb;
  import clsup_pkg::*;

  localparam logic [1:0]  OP_NONE     = 2'd3;
  localparam int          LATENCY     = 2;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam cfg_t RESET_CFG = '{11'd513, 16'd1000, 8'd3, 8'd0, 8'd1, 8'd2};

  typedef struct {
    item_t   it;
    bit      pinned;
    result_t want;
  } row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  item_valid = 1'b0;
  logic                  item_stall;
  item_t                 item_in = '0;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  result_t               result_out;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  can_link_supervisor_unit u_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item_in),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result_out),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // link model state
  cfg_t        link_cfg;
  logic [31:0] ms_now, last_good_ms;
  logic [15:0] last_seq;
  logic        seq_known, in_timeout, slot_full;
  slot_t       slot;
  logic [31:0] cnt_valid, cnt_lost, cnt_overflow, cnt_wrong;
  logic [3:0]  leds;

  result_t     status_q [$];
  row_t        item_tags_q [$];
  result_t     model_status, want_status;
  row_t        tag;
  int unsigned items_sent = 0;
  int unsigned statuses_checked = 0;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned stall_left = 0;
  bit          stall_on = 1'b1;
  cfg_t        cur_cfg = RESET_CFG;
  logic [15:0] seq_cursor = '0;

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic result_t next_link_status(item_t it);
    result_t     st;
    logic [15:0] gap;
    st = '0;
    case (it.opcode)
      OP_TICK: ms_now = ms_now + 32'd1;
      OP_FRAME: begin
        if (!it.extended_flag && !it.remote_flag && it.frame_id == 29'(link_cfg.accepted_id)
            && it.length_code == REQUIRED_DLC) begin
          if (slot_full) cnt_overflow = cnt_overflow + 32'd1;
          slot.ok     = it.payload_ok;
          slot.seq    = it.sequence_req;
          slot.vstate = it.vehicle_state;
          slot.flt    = it.fault;
          slot_full   = 1'b1;
        end else begin
          cnt_wrong = cnt_wrong + 32'd1;
        end
      end
      OP_POLL: begin
        if (slot_full) begin
          slot_full = 1'b0;
          if (slot.ok) begin
            cnt_valid = cnt_valid + 32'd1;
            gap = slot.seq - last_seq;
            if (seq_known && gap > 16'd1 && gap < SEQ_HALF_RANGE)
              cnt_lost = cnt_lost + 32'(gap) - 32'd1;
            last_seq     = slot.seq;
            seq_known    = 1'b1;
            last_good_ms = ms_now;
            if (in_timeout) begin
              in_timeout = 1'b0;
              st.recovered_event = 1'b1;
            end
            if (slot.flt != 8'd0 || slot.vstate == link_cfg.critical_code) leds = LED_RED;
            else if (slot.vstate == link_cfg.normal_code) leds = LED_YELLOW;
            else if (slot.vstate == link_cfg.high_rpm_code) leds = LED_BLUE;
            else if (slot.vstate == link_cfg.over_temp_code) leds = LED_GREEN;
            else leds = LED_OFF;
          end else begin
            st.payload_error = 1'b1;
          end
        end
        if (!in_timeout && (ms_now - last_good_ms) > 32'(link_cfg.timeout_ms)) begin
          in_timeout = 1'b1;
          st.timeout_event = 1'b1;
        end
        if (in_timeout) leds = ms_now[BLINK_BIT] ? LED_YELLOW : LED_RED;
      end
      default: ;
    endcase
    st.led_pattern    = leds;
    st.timed_out      = in_timeout;
    st.valid_count    = cnt_valid;
    st.lost_count     = cnt_lost;
    st.overflow_count = cnt_overflow;
    st.wrong_count    = cnt_wrong;
    return st;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("[%0t] status %0d %s: got %0h, want %0h", $time, statuses_checked, what, got, want);
    mismatches++;
  endtask

  task automatic compare_status(result_t got, result_t want);
    if (got.led_pattern !== want.led_pattern)
      report_mismatch("led_pattern", 32'(got.led_pattern), 32'(want.led_pattern));
    if (got.timed_out !== want.timed_out)
      report_mismatch("timed_out", 32'(got.timed_out), 32'(want.timed_out));
    if (got.recovered_event !== want.recovered_event)
      report_mismatch("recovered_event", 32'(got.recovered_event), 32'(want.recovered_event));
    if (got.timeout_event !== want.timeout_event)
      report_mismatch("timeout_event", 32'(got.timeout_event), 32'(want.timeout_event));
    if (got.payload_error !== want.payload_error)
      report_mismatch("payload_error", 32'(got.payload_error), 32'(want.payload_error));
    if (got.valid_count !== want.valid_count)
      report_mismatch("valid_count", got.valid_count, want.valid_count);
    if (got.lost_count !== want.lost_count)
      report_mismatch("lost_count", got.lost_count, want.lost_count);
    if (got.overflow_count !== want.overflow_count)
      report_mismatch("overflow_count", got.overflow_count, want.overflow_count);
    if (got.wrong_count !== want.wrong_count)
      report_mismatch("wrong_count", got.wrong_count, want.wrong_count);
  endtask

  // predict on accepted items, check accepted statuses
  always @(posedge clk) begin
    if (rst) begin
      link_cfg     = RESET_CFG;
      ms_now       = '0;
      last_good_ms = '0;
      last_seq     = '0;
      seq_known    = 1'b0;
      in_timeout   = 1'b0;
      slot_full    = 1'b0;
      slot         = '0;
      cnt_valid    = '0;
      cnt_lost     = '0;
      cnt_overflow = '0;
      cnt_wrong    = '0;
      leds         = LED_OFF;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ACCEPTED_ID:    link_cfg.accepted_id    = cfg_data[10:0];
          REG_TIMEOUT_MS:     link_cfg.timeout_ms     = cfg_data;
          REG_CRITICAL_CODE:  link_cfg.critical_code  = cfg_data[7:0];
          REG_NORMAL_CODE:    link_cfg.normal_code    = cfg_data[7:0];
          REG_HIGH_RPM_CODE:  link_cfg.high_rpm_code  = cfg_data[7:0];
          REG_OVER_TEMP_CODE: link_cfg.over_temp_code = cfg_data[7:0];
          default: ;
        endcase
      end
      if (item_valid && !item_stall) begin
        model_status = next_link_status(item_in);
        tag = item_tags_q.pop_front();
        status_q.push_back(tag.pinned ? tag.want : model_status);
      end
      if (result_valid && !result_stall) begin
        if (status_q.size() == 0) begin
          report_mismatch("status with none expected", result_out.valid_count, '0);
        end else begin
          want_status = status_q.pop_front();
          compare_status(result_out, want_status);
          statuses_checked++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      result_stall <= 1'b1;
    end else begin
      result_stall <= 1'b0;
      if (stall_on && $urandom_range(0, 2) == 0) stall_left <= pick_gap();
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic item_t op_item(logic [1:0] op);
    item_t it;
    it = '0;
    it.opcode = op;
    return it;
  endfunction

  function automatic item_t frame_item(logic ext, logic rtr, logic [28:0] id, logic [3:0] dlc,
                                       logic ok, logic [15:0] seq, logic [7:0] vs,
                                       logic [7:0] flt);
    item_t it;
    it.opcode        = OP_FRAME;
    it.extended_flag = ext;
    it.remote_flag   = rtr;
    it.frame_id      = id;
    it.length_code   = dlc;
    it.payload_ok    = ok;
    it.sequence_req  = seq;
    it.vehicle_state = vs;
    it.fault         = flt;
    return it;
  endfunction

  function automatic item_t good_frame(logic ok, logic [15:0] seq, logic [7:0] vs,
                                       logic [7:0] flt);
    return frame_item(1'b0, 1'b0, 29'(RESET_CFG.accepted_id), REQUIRED_DLC, ok, seq, vs, flt);
  endfunction

  function automatic row_t pinned_row(item_t it, logic [31:0] v, logic [31:0] o, logic [31:0] w);
    row_t row;
    row.it     = it;
    row.pinned = 1'b1;
    row.want   = '0;
    row.want.valid_count    = v;
    row.want.overflow_count = o;
    row.want.wrong_count    = w;
    return row;
  endfunction

  function automatic row_t free_row(item_t it);
    row_t row;
    row.it     = it;
    row.pinned = 1'b0;
    row.want   = '0;
    return row;
  endfunction

  function automatic item_t rand_item(int unsigned tick_pct);
    item_t       it;
    logic [95:0] raw;
    int unsigned r;
    bit          good;
    raw = {$urandom, $urandom, $urandom};
    it = raw[$bits(item_t)-1:0];
    r = $urandom_range(0, 99);
    if (r < tick_pct) begin
      it.opcode = OP_TICK;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 55) it.opcode = OP_FRAME;
      else if (r < 93) it.opcode = OP_POLL;
      else it.opcode = OP_NONE;
    end
    if (it.opcode == OP_FRAME) begin
      good = $urandom_range(0, 99) < 75;
      if (good || $urandom_range(0, 1)) it.extended_flag = 1'b0;
      if (good || $urandom_range(0, 1)) it.remote_flag = 1'b0;
      if (good || $urandom_range(0, 1)) it.frame_id = 29'(cur_cfg.accepted_id);
      if (good || $urandom_range(0, 1)) it.length_code = REQUIRED_DLC;
      it.payload_ok = $urandom_range(0, 99) < 85;
      if ($urandom_range(0, 99) < 75) seq_cursor = seq_cursor + 16'($urandom_range(0, 3));
      else seq_cursor = 16'($urandom);
      it.sequence_req = seq_cursor;
      if ($urandom_range(0, 99) < 75) it.vehicle_state = 8'($urandom_range(0, 4));
      if ($urandom_range(0, 99) < 80) it.fault = '0;
    end
    return it;
  endfunction

  task automatic send_row(row_t row, int unsigned gap);
    item_tags_q.push_back(row);
    if (gap != 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_in <= row.it;
    item_valid <= 1'b1;
    do @(posedge clk); while (item_stall);
    items_sent++;
  endtask

  task automatic wait_all_checked();
    item_valid <= 1'b0;
    while (statuses_checked != items_sent) @(posedge clk);
  endtask

  task automatic write_regs(cfg_t c);
    logic [CFG_IDX_W-1:0]  idx [6];
    logic [CFG_DATA_W-1:0] val [6];
    idx[0] = REG_ACCEPTED_ID;    val[0] = CFG_DATA_W'(c.accepted_id);
    idx[1] = REG_TIMEOUT_MS;     val[1] = c.timeout_ms;
    idx[2] = REG_CRITICAL_CODE;  val[2] = CFG_DATA_W'(c.critical_code);
    idx[3] = REG_NORMAL_CODE;    val[3] = CFG_DATA_W'(c.normal_code);
    idx[4] = REG_HIGH_RPM_CODE;  val[4] = CFG_DATA_W'(c.high_rpm_code);
    idx[5] = REG_OVER_TEMP_CODE; val[5] = CFG_DATA_W'(c.over_temp_code);
    for (int i = 0; i < 6; i++) begin
      cfg_index <= idx[i];
      cfg_data <= val[i];
      cfg_valid <= 1'b1;
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  initial begin
    row_t        plan [$];
    cfg_t        c;
    int unsigned n, tick_pct;
    bit          quiet;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    plan.push_back(pinned_row(op_item(OP_POLL), 0, 0, 0));
    plan.push_back(pinned_row(frame_item(1'b1, 1'b0, 29'd513, REQUIRED_DLC, 1'b1, 16'd5,
                                         8'd0, 8'd0), 0, 0, 1));
    plan.push_back(pinned_row(frame_item(1'b0, 1'b1, 29'd513, REQUIRED_DLC, 1'b1, 16'd5,
                                         8'd0, 8'd0), 0, 0, 2));
    plan.push_back(pinned_row(frame_item(1'b0, 1'b0, 29'h1FFF_FFFF, REQUIRED_DLC, 1'b1,
                                         16'hFFFF, 8'hFF, 8'hFF), 0, 0, 3));
    plan.push_back(pinned_row(frame_item(1'b0, 1'b0, 29'h1000_0201, REQUIRED_DLC, 1'b1,
                                         16'd5, 8'd0, 8'd0), 0, 0, 4));
    plan.push_back(pinned_row(frame_item(1'b0, 1'b0, 29'd513, 4'hF, 1'b1, 16'd5, 8'd0, 8'd0),
                              0, 0, 5));
    plan.push_back(pinned_row(good_frame(1'b1, 16'hFFFF, 8'd0, 8'd0), 0, 0, 5));
    // overwrite a pending slot
    plan.push_back(pinned_row(good_frame(1'b1, 16'd0, 8'hFF, 8'd0), 0, 1, 5));
    plan.push_back(pinned_row(op_item(OP_POLL), 1, 1, 5));
    plan.push_back(pinned_row(op_item(OP_POLL), 1, 1, 5));
    plan.push_back(pinned_row(op_item(OP_TICK), 1, 1, 5));
    plan.push_back(pinned_row('1, 1, 1, 5));
    plan.push_back(free_row(good_frame(1'b1, 16'd2, 8'd3, 8'd0)));
    plan.push_back(free_row(op_item(OP_POLL)));
    plan.push_back(free_row(good_frame(1'b1, 16'h8002, 8'd0, 8'd0)));
    plan.push_back(free_row(op_item(OP_POLL)));
    plan.push_back(free_row(good_frame(1'b1, 16'h8003, 8'd1, 8'd0)));
    plan.push_back(free_row(op_item(OP_POLL)));
    plan.push_back(free_row(good_frame(1'b1, 16'h8004, 8'd2, 8'd0)));
    plan.push_back(free_row(op_item(OP_POLL)));
    plan.push_back(free_row(good_frame(1'b0, 16'h8006, 8'd1, 8'hFF)));
    plan.push_back(free_row(op_item(OP_POLL)));
    plan.push_back(free_row(good_frame(1'b1, 16'h800A, 8'd2, 8'h01)));
    plan.push_back(free_row(op_item(OP_POLL)));
    foreach (plan[i]) send_row(plan[i], pick_gap());
    wait_all_checked();

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: c = '{11'd0, 16'd0, 8'd0, 8'd0, 8'd0, 8'd0};
        1: c = '{11'h7FF, 16'hFFFF, 8'hFF, 8'hFE, 8'hFD, 8'hFC};
        default: begin
          c.accepted_id    = 11'($urandom);
          c.timeout_ms     = 16'($urandom_range(0, 40));
          c.critical_code  = 8'($urandom_range(0, 4));
          c.normal_code    = 8'($urandom_range(0, 4));
          c.high_rpm_code  = 8'($urandom_range(0, 4));
          c.over_temp_code = 8'($urandom_range(0, 4));
        end
      endcase
      repeat (LATENCY) @(posedge clk);
      write_regs(c);
      cur_cfg = c;
      n        = (p == 3) ? 250 : 25;
      tick_pct = (p == 3) ? 94 : 35;
      quiet    = (p == 4);
      stall_on <= (p != 5);
      for (int k = 0; k < n; k++) begin
        if (k == n / 2) wait_all_checked();
        send_row(free_row(rand_item(tick_pct)), quiet ? 0 : pick_gap());
      end
      wait_all_checked();
    end

    repeat (LATENCY + 4) @(posedge clk);
    if (status_q.size() != 0) report_mismatch("statuses left over", status_q.size(), '0);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: can_link_supervisor_unit.f
rtl/clsup_pkg.sv
rtl/clsup_cfg.sv
rtl/clsup_core.sv
rtl/can_link_supervisor_unit.sv
tb/sv/can_link_supervisor_unit_tb.sv
